// ===== hdl/bdch_pkg.sv =====
// ----------------------------------------------------------------------------
// bdch_pkg: shared types and constants for the button debounce block
// Item layouts, event codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bdch_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int AGE_WIDTH_DEF   = 16;
  localparam int IO_BUTTONS      = 4;   // buttons carried by the item fields
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_IDX_WIDTH   = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DOUBLE   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HOLD     = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_RST   = 16'd300;
  localparam logic [CFG_WIDTH-1:0] HOLD_RST     = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_HOLD   = 2'd3
  } event_t;

  typedef struct packed {
    logic [3:0] raw_levels;
    logic [3:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_button0;
    logic [1:0] event_button1;
    logic [1:0] event_button2;
    logic [1:0] event_button3;
    logic [3:0] pressed_mask;
  } out_item_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] double_click_ticks;
    logic [CFG_WIDTH-1:0] hold_ticks;
  } cfg_t;

  // What one lane reports after the tick in hand
  typedef struct packed {
    event_t evt;
    logic   level;
  } lane_status_t;

endpackage

`default_nettype wire

// ===== hdl/bdch_lane.sv =====
// ----------------------------------------------------------------------------
// bdch_lane: debounce and click / double click / hold detection, one button
// Holds the per-button state and shows its post-tick values combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bdch_lane
  import bdch_pkg::*;
#(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         tick,
  input  wire logic         reading,
  input  wire logic         clear,
  input  wire cfg_t         cfg,
  output lane_status_t      status
);

  localparam int CMP_W = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;

  logic                 level, level_next;
  logic                 prev, prev_next;
  logic                 last_raw;
  logic                 pending, pending_next;
  event_t               evt, evt_next;
  logic [AGE_WIDTH-1:0] stable_age, stable_age_next;
  logic [AGE_WIDTH-1:0] press_age, press_age_next;
  logic [AGE_WIDTH-1:0] click_age, click_age_next;

  function automatic logic [AGE_WIDTH-1:0] sat_inc(input logic [AGE_WIDTH-1:0] a);
    sat_inc = (&a) ? a : a + 1'b1;
  endfunction

  logic [CMP_W-1:0] deb_c, dbl_c, hold_c;
  assign deb_c  = CMP_W'(cfg.debounce_ticks);
  assign dbl_c  = CMP_W'(cfg.double_click_ticks);
  assign hold_c = CMP_W'(cfg.hold_ticks);

  always_comb begin
    logic short_press;
    evt_next        = clear ? EV_NONE : evt;
    press_age_next  = sat_inc(press_age);
    click_age_next  = sat_inc(click_age);
    stable_age_next = (reading != last_raw) ? '0 : sat_inc(stable_age);
    level_next      = level;
    pending_next    = pending;

    // accept the level once it has been stable long enough
    if (CMP_W'(stable_age_next) > deb_c && reading != level) begin
      level_next = reading;
      if (reading) begin
        press_age_next = '0;
      end
    end

    short_press = CMP_W'(press_age_next) < hold_c;

    if (level_next && evt_next == EV_NONE && !short_press) begin
      evt_next     = EV_HOLD;
      pending_next = 1'b0;
    end else begin
      if (!level_next && prev && short_press) begin
        if (pending && CMP_W'(click_age_next) <= dbl_c) begin
          evt_next     = EV_DOUBLE;
          pending_next = 1'b0;
        end else begin
          pending_next   = 1'b1;
          click_age_next = '0;
        end
      end
      if (pending_next && evt_next == EV_NONE && CMP_W'(click_age_next) > dbl_c) begin
        evt_next     = EV_CLICK;
        pending_next = 1'b0;
      end
    end
    prev_next = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= 1'b0;
      prev       <= 1'b0;
      last_raw   <= 1'b0;
      pending    <= 1'b0;
      evt        <= EV_NONE;
      stable_age <= '0;
      press_age  <= '0;
      click_age  <= '0;
    end else if (tick) begin
      level      <= level_next;
      prev       <= prev_next;
      last_raw   <= reading;
      pending    <= pending_next;
      evt        <= evt_next;
      stable_age <= stable_age_next;
      press_age  <= press_age_next;
      click_age  <= click_age_next;
    end
  end

  assign status.evt   = evt_next;
  assign status.level = level_next;

endmodule

`default_nettype wire

// ===== hdl/bdch_merge.sv =====
// ----------------------------------------------------------------------------
// bdch_merge: gather lane results into the output item register
// Packs the reported buttons into one result and holds it while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bdch_merge
  import bdch_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire logic                            drain,
  input  wire lane_status_t [NUM_BUTTONS-1:0]  status,
  output logic                                 out_valid,
  output out_item_t                            out_item
);

  logic [IO_BUTTONS-1:0][1:0] evts;
  logic [IO_BUTTONS-1:0]      levels;
  out_item_t                  item_next;

  for (genvar i = 0; i < IO_BUTTONS; i++) begin : g_pick
    if (i < NUM_BUTTONS) begin : g_real
      assign evts[i]   = status[i].evt;
      assign levels[i] = status[i].level;
    end else begin : g_absent
      assign evts[i]   = 2'b00;
      assign levels[i] = 1'b0;
    end
  end

  always_comb begin
    item_next.event_button0 = evts[0];
    item_next.event_button1 = evts[1];
    item_next.event_button2 = evts[2];
    item_next.event_button3 = evts[3];
    item_next.pressed_mask  = levels;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_debounce_click_hold_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_hold_core: multi-button debounce and gesture detect
// One lane per button debounces its level and latches click, double click
// or hold; a merge stage packs the lanes into one result item per tick.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_item  (raw_levels, clear_mask)
//   out      output     out_valid / out_stall out_item (events, pressed_mask)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One tick item per clock while not stalled; its result appears in the cycle
// after acceptance, set by the single output register behind the lane logic.
// Reset clears all lane state and loads the register defaults (50/300/1000).
// in_stall rises only while a result waits and out_stall holds it; an item
// is taken in the same cycle the waiting result leaves.
// cfg_ready is always high; writes to an unknown index are dropped.
//
`default_nettype none

module button_debounce_click_hold_core
  import bdch_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int AGE_WIDTH   = AGE_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_item,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_item,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

  cfg_t                              cfg;
  lane_status_t [NUM_BUTTONS-1:0]    status;
  logic                              tick;

  // Stall input only while the output register is full and held
  assign in_stall  = out_valid && out_stall;
  assign tick      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Register file: three tick thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RST;
      cfg.double_click_ticks <= DOUBLE_RST;
      cfg.hold_ticks         <= HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg.debounce_ticks     <= cfg_data;
        CFG_DOUBLE:   cfg.double_click_ticks <= cfg_data;
        CFG_HOLD:     cfg.hold_ticks         <= cfg_data;
        default:      ;
      endcase
    end
  end

  // One lane per button; buttons past the item fields see a released level
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic reading, clear;
    if (b < IO_BUTTONS) begin : g_io
      assign reading = in_item.raw_levels[b];
      assign clear   = in_item.clear_mask[b];
    end else begin : g_idle
      assign reading = 1'b0;
      assign clear   = 1'b0;
    end

    bdch_lane #(
      .AGE_WIDTH (AGE_WIDTH)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .tick    (tick),
      .reading (reading),
      .clear   (clear),
      .cfg     (cfg),
      .status  (status[b])
    );
  end

  bdch_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (tick),
    .drain     (!out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Checks on the flow through the output register
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    tick |=> out_valid)
    else $error("accepted item produced no result");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !tick) |=> !out_valid)
    else $error("result appeared without an accepted item");

  a_taken_result_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !tick) |=> !out_valid)
    else $error("delivered result repeated");

endmodule

`default_nettype wire
